@@ sv/krf_pkg.sv @@
`default_nettype none

package krf_pkg;

  localparam int FracBitsDef = 16;
  localparam int RateW       = 32;
  localparam int VarW        = 32;
  localparam int CfgIdxW     = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_VAR    = 2'd0,
    CFG_PROC_NOISE   = 2'd1,
    CFG_SENSOR_NOISE = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DIVI,
    ST_DIV,
    ST_MULC,
    ST_CORR,
    ST_MULV,
    ST_OUT
  } krf_state_e;

  typedef struct packed {
    logic imu_load;
    logic seed;
    logic odo_load;
    logic predict;
    logic div_init;
    logic div_step;
    logic mul_corr;
    logic corr;
    logic mul_var;
    logic vupd;
  } krf_cmd_t;

  typedef struct packed {
    logic out_busy;
  } krf_sts_t;

  function automatic logic [VarW-1:0] start_var_reset(input int frac);
    logic [63:0] v;
    v = 64'd1000 << frac;
    if (v > 64'h0000_0000_FFFF_FFFF) begin
      return '1;
    end
    return v[VarW-1:0];
  endfunction

  function automatic logic [VarW-1:0] proc_noise_reset(input int frac);
    logic [63:0] v;
    v = 64'd4 << frac;
    return v[VarW-1:0];
  endfunction

  function automatic logic [VarW-1:0] sensor_noise_reset(input int frac);
    logic [63:0] v;
    v = 64'd1 << (frac - 1);
    return v[VarW-1:0];
  endfunction

  function automatic logic signed [RateW-1:0] sat_s32(input logic signed [47:0] v);
    if (v > 48'sh0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -48'sh0000_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[RateW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/krf_ctrl.sv @@
`default_nettype none

module krf_ctrl #(
  parameter int FRAC_BITS = krf_pkg::FracBitsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_func_i,
  output logic                   in_stall_o,
  input  wire krf_pkg::krf_sts_t sts_i,
  output krf_pkg::krf_cmd_t      cmd_o
);

  localparam int CntW = $clog2(FRAC_BITS);
  localparam logic [CntW-1:0] CntLast = CntW'(FRAC_BITS - 1);

  krf_pkg::krf_state_e state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                awaiting_q, awaiting_d;
  logic                accept;

  assign in_stall_o = (state_q != krf_pkg::ST_IDLE);
  assign accept     = in_valid_i && (state_q == krf_pkg::ST_IDLE);

  always_comb begin
    state_d    = state_q;
    awaiting_d = awaiting_q;
    cnt_d      = cnt_q;
    unique case (state_q)
      krf_pkg::ST_IDLE: begin
        if (accept && !in_func_i) begin
          if (awaiting_q) begin
            awaiting_d = 1'b0;
          end else begin
            state_d = krf_pkg::ST_PRED;
          end
        end
      end
      krf_pkg::ST_PRED: state_d = krf_pkg::ST_DIVI;
      krf_pkg::ST_DIVI: begin
        state_d = krf_pkg::ST_DIV;
        cnt_d   = '0;
      end
      krf_pkg::ST_DIV: begin
        if (cnt_q == CntLast) begin
          state_d = krf_pkg::ST_MULC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      krf_pkg::ST_MULC: state_d = krf_pkg::ST_CORR;
      krf_pkg::ST_CORR: state_d = krf_pkg::ST_MULV;
      krf_pkg::ST_MULV: state_d = krf_pkg::ST_OUT;
      krf_pkg::ST_OUT: begin
        if (!sts_i.out_busy) begin
          state_d = krf_pkg::ST_IDLE;
        end
      end
      default: state_d = krf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      krf_pkg::ST_IDLE: begin
        cmd_o.imu_load = accept && in_func_i;
        cmd_o.seed     = accept && !in_func_i && awaiting_q;
        cmd_o.odo_load = accept && !in_func_i && !awaiting_q;
      end
      krf_pkg::ST_PRED: cmd_o.predict  = 1'b1;
      krf_pkg::ST_DIVI: cmd_o.div_init = 1'b1;
      krf_pkg::ST_DIV:  cmd_o.div_step = 1'b1;
      krf_pkg::ST_MULC: cmd_o.mul_corr = 1'b1;
      krf_pkg::ST_CORR: cmd_o.corr     = 1'b1;
      krf_pkg::ST_MULV: cmd_o.mul_var  = 1'b1;
      krf_pkg::ST_OUT:  cmd_o.vupd     = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= krf_pkg::ST_IDLE;
      awaiting_q <= 1'b1;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      awaiting_q <= awaiting_d;
      cnt_q      <= cnt_d;
    end
  end

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == krf_pkg::ST_DIV && cnt_q == CntLast) |=> (state_q == krf_pkg::ST_MULC))
    else $error("Division did not end after the last quotient bit.");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("More than one datapath command in one cycle.");

  a_busy_seeded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != krf_pkg::ST_IDLE) |-> !awaiting_q)
    else $error("Update started before the filter was seeded.");

endmodule

`default_nettype wire

@@ sv/krf_dpath.sv @@
`default_nettype none

module krf_dpath #(
  parameter int FRAC_BITS = krf_pkg::FracBitsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic signed [krf_pkg::RateW-1:0]   in_rate_i,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [krf_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [krf_pkg::VarW-1:0]           cfg_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [krf_pkg::RateW-1:0]        out_filtered_rate_o,
  output logic [krf_pkg::VarW-1:0]                out_rate_variance_o,
  input  wire krf_pkg::krf_cmd_t                  cmd_i,
  output krf_pkg::krf_sts_t                       sts_o
);

  localparam int MaW  = 34;
  localparam int MbW  = FRAC_BITS + 2;
  localparam int PW   = MaW + MbW;
  localparam int CorW = PW - FRAC_BITS;
  localparam logic [FRAC_BITS:0]    One  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [PW-1:0]  Half = PW'(1) <<< (FRAC_BITS - 1);

  logic [krf_pkg::VarW-1:0]         start_q, proc_q, sens_q;
  logic signed [krf_pkg::RateW-1:0] est_q, last_q, held_q;
  logic [krf_pkg::VarW-1:0]         var_q;
  logic signed [32:0]               diff_q, innov_q;
  logic [32:0]                      den_q;
  logic [33:0]                      rem_q;
  logic [FRAC_BITS-1:0]             gain_q;
  logic                             rzero_q;
  logic signed [PW-1:0]             prod_q;
  logic                             out_valid_q;
  logic signed [krf_pkg::RateW-1:0] out_rate_q;
  logic [krf_pkg::VarW-1:0]         out_var_q;

  logic signed [krf_pkg::RateW-1:0] est_pred, est_corr;
  logic [32:0]                      var_sum;
  logic [krf_pkg::VarW-1:0]         var_pred, var_new;
  logic [33:0]                      rem_sh, rem_sub;
  logic                             q_bit;
  logic [FRAC_BITS:0]               one_m_gain;
  logic signed [MaW-1:0]            mul_a;
  logic signed [MbW-1:0]            mul_b;
  logic signed [PW-1:0]             prod, rnd;
  logic signed [CorW-1:0]           corr;

  assign cfg_ready_o = 1'b1;

  assign est_pred = krf_pkg::sat_s32({{16{est_q[31]}}, est_q} + {{15{diff_q[32]}}, diff_q});
  assign var_sum  = {1'b0, var_q} + {1'b0, proc_q};
  assign var_pred = var_sum[32] ? '1 : var_sum[31:0];

  assign rem_sh  = {rem_q[32:0], 1'b0};
  assign q_bit   = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  assign one_m_gain = One - {1'b0, gain_q};
  assign mul_a = cmd_i.mul_var ? {2'b00, var_q} : {innov_q[32], innov_q};
  assign mul_b = cmd_i.mul_var ? {1'b0, one_m_gain} : {2'b00, gain_q};
  assign prod  = mul_a * mul_b;

  assign rnd      = prod_q + Half;
  assign corr     = rnd[PW-1:FRAC_BITS];
  assign est_corr = krf_pkg::sat_s32({{16{est_q[31]}}, est_q}
                                     + {{(48 - CorW){corr[CorW-1]}}, corr});
  assign var_new  = rnd[FRAC_BITS+31:FRAC_BITS];

  assign sts_o.out_busy = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= krf_pkg::start_var_reset(FRAC_BITS);
      proc_q  <= krf_pkg::proc_noise_reset(FRAC_BITS);
      sens_q  <= krf_pkg::sensor_noise_reset(FRAC_BITS);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (krf_pkg::cfg_idx_e'(cfg_index_i))
        krf_pkg::CFG_START_VAR:    start_q <= cfg_data_i;
        krf_pkg::CFG_PROC_NOISE:   proc_q  <= cfg_data_i;
        krf_pkg::CFG_SENSOR_NOISE: sens_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q  <= '0;
      var_q  <= krf_pkg::start_var_reset(FRAC_BITS);
      last_q <= '0;
      held_q <= '0;
    end else begin
      if (cmd_i.imu_load) begin
        held_q <= in_rate_i;
      end
      if (cmd_i.seed) begin
        est_q  <= in_rate_i;
        var_q  <= start_q;
        last_q <= in_rate_i;
      end
      if (cmd_i.odo_load) begin
        last_q <= in_rate_i;
      end
      if (cmd_i.predict) begin
        est_q <= est_pred;
        var_q <= var_pred;
      end
      if (cmd_i.corr) begin
        est_q <= est_corr;
      end
      if (cmd_i.vupd) begin
        var_q <= var_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.odo_load) begin
      diff_q <= {in_rate_i[31], in_rate_i} - {last_q[31], last_q};
    end
    if (cmd_i.div_init) begin
      den_q   <= {1'b0, var_q} + {1'b0, sens_q};
      rem_q   <= {2'b00, var_q};
      rzero_q <= (sens_q == '0);
      gain_q  <= ((sens_q == '0) && (var_q != '0)) ? '1 : '0;
      innov_q <= {held_q[31], held_q} - {est_q[31], est_q};
    end
    if (cmd_i.div_step && !rzero_q) begin
      gain_q <= {gain_q[FRAC_BITS-2:0], q_bit};
      rem_q  <= q_bit ? rem_sub : rem_sh;
    end
    if (cmd_i.mul_corr || cmd_i.mul_var) begin
      prod_q <= prod;
    end
    if (cmd_i.vupd) begin
      out_rate_q <= est_q;
      out_var_q  <= var_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.vupd) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_filtered_rate_o = out_rate_q;
  assign out_rate_variance_o = out_var_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.vupd |-> !(out_valid_q && out_stall_i))
    else $error("A pending result was overwritten.");

  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.vupd))
    else $error("Result became valid without an update.");

  a_update_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.vupd |=> out_valid_q)
    else $error("Update did not produce a result.");

endmodule

`default_nettype wire

@@ sv/scalar_kalman_rate_fusion.sv @@
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_stall_o   in_func_i, in_rate_i
// out       output     out_valid_o/out_stall_i out_filtered_rate_o, out_rate_variance_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An IMU transaction or the first odometry transaction is taken without starting an update.
// A later odometry transaction runs predict, divider init, the bit-serial gain divide
// (one quotient bit per cycle), gain multiply, correction, variance multiply, output.
// The input stalls while an update is in progress; a result waiting in the
// output register only holds the final step of the next update.
// Reset clears the filter to wait for its first odometry sample.
`default_nettype none

module scalar_kalman_rate_fusion #(
  parameter int FRAC_BITS = krf_pkg::FracBitsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               in_func_i,
  input  wire logic signed [krf_pkg::RateW-1:0]   in_rate_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [krf_pkg::RateW-1:0]        out_filtered_rate_o,
  output logic [krf_pkg::VarW-1:0]                out_rate_variance_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [krf_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [krf_pkg::VarW-1:0]           cfg_data_i
);

  krf_pkg::krf_cmd_t cmd;
  krf_pkg::krf_sts_t sts;

  krf_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_func_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  krf_dpath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_rate_i           (in_rate_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_filtered_rate_o (out_filtered_rate_o),
    .out_rate_variance_o (out_rate_variance_o),
    .cmd_i               (cmd),
    .sts_o               (sts)
  );

endmodule

`default_nettype wire
